FILE: hw/rtl/normal_equation_accumulator_assert.svh
// Assertion macros for the normal-equation accumulator.
// Used by the top level only; needs nothing else.
`ifndef NORMAL_EQUATION_ACCUMULATOR_ASSERT_SVH
`define NORMAL_EQUATION_ACCUMULATOR_ASSERT_SVH

// A condition that must hold in the same cycle as its trigger.
`define NEA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define NEA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/nea_pkg.sv
// Types, constants and the saturating add of the normal-equation accumulator.
// Depends on nothing; used by the channel interfaces and the top level.
package nea_pkg;

   localparam int DIM = 6;
   localparam int TRI = 21;
   localparam int JAC_W = 24;
   localparam int PROD_W = 2 * JAC_W;
   localparam int SUM_W = 64;

   localparam logic [2:0] LAST_ROW = 3'(DIM - 1);

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // Position of each (row, column) of the symmetric matrix in upper-triangle storage.
   localparam logic [4:0] TRI_INDEX [0:DIM-1][0:DIM-1] = '{
      '{5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5},
      '{5'd1,  5'd6,  5'd7,  5'd8,  5'd9,  5'd10},
      '{5'd2,  5'd7,  5'd11, 5'd12, 5'd13, 5'd14},
      '{5'd3,  5'd8,  5'd12, 5'd15, 5'd16, 5'd17},
      '{5'd4,  5'd9,  5'd13, 5'd16, 5'd18, 5'd19},
      '{5'd5,  5'd10, 5'd14, 5'd17, 5'd19, 5'd20}
   };

   typedef enum logic [1:0] {
      CMD_ACCUM = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2
   } command_type;

   typedef struct packed {
      logic [1:0]              command;
      logic signed [JAC_W-1:0] jac_0;
      logic signed [JAC_W-1:0] jac_1;
      logic signed [JAC_W-1:0] jac_2;
      logic signed [JAC_W-1:0] jac_3;
      logic signed [JAC_W-1:0] jac_4;
      logic signed [JAC_W-1:0] jac_5;
      logic signed [JAC_W-1:0] residual;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]              row;
      logic signed [SUM_W-1:0] h_col0;
      logic signed [SUM_W-1:0] h_col1;
      logic signed [SUM_W-1:0] h_col2;
      logic signed [SUM_W-1:0] h_col3;
      logic signed [SUM_W-1:0] h_col4;
      logic signed [SUM_W-1:0] h_col5;
      logic signed [SUM_W-1:0] g_entry;
      logic                    saturated;
      logic                    last;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] value;
      logic                    overflow;
   } sat_result_type;

   // Adds a sign-extended product to a sum, clamping at the signed range.
   function automatic sat_result_type sat_accum(logic signed [SUM_W-1:0]  sum,
                                                logic signed [PROD_W-1:0] prod);
      logic signed [SUM_W-1:0] ext;
      logic signed [SUM_W-1:0] raw;
      sat_result_type          res;
      ext = SUM_W'(prod);
      raw = sum + ext;
      res.overflow = (sum[SUM_W-1] == ext[SUM_W-1]) && (raw[SUM_W-1] != sum[SUM_W-1]);
      if (res.overflow) begin
         res.value = sum[SUM_W-1] ? SUM_MIN : SUM_MAX;
      end else begin
         res.value = raw;
      end
      return res;
   endfunction

endpackage

FILE: hw/rtl/nea_req_if.sv
// Request channel of the normal-equation accumulator: valid, ready and one term.
// Depends on nea_pkg.
interface nea_req_if;
   import nea_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/nea_rsp_if.sv
// Response channel of the normal-equation accumulator: valid, ready and one row.
// Depends on nea_pkg.
interface nea_rsp_if;
   import nea_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/normal_equation_accumulator.sv
// Normal-equation accumulator, top level; uses nea_pkg, nea_req_if, nea_rsp_if.
// Accumulate and clear items are taken one per cycle while no read holds the sum stage;
// they pass through the input register and product register to the sum update.
// A read item passes the input and product registers and yields six rows, one per
// cycle while the response side is ready; it holds the sum stage while they go out.
// Reset is synchronous, active high, and zeroes the sums and the saturation flag.
`include "normal_equation_accumulator_assert.svh"

module normal_equation_accumulator (
   input logic    clock,
   input logic    reset,
   nea_req_if.sink   req_ch,
   nea_rsp_if.source rsp_ch
);
   import nea_pkg::*;

   // Stage one: the accepted item, registered as it arrives.
   logic                    s1_valid_ff, s1_valid_in;
   logic [1:0]              s1_cmd_ff;
   logic signed [JAC_W-1:0] s1_jac_ff [DIM];
   logic signed [JAC_W-1:0] s1_res_ff;

   // Stage two: the 21 matrix products and 6 gradient products of the item.
   logic                     s2_valid_ff, s2_valid_in;
   logic [1:0]               s2_cmd_ff;
   logic signed [PROD_W-1:0] prod_h_ff [TRI];
   logic signed [PROD_W-1:0] prod_g_ff [DIM];
   logic signed [PROD_W-1:0] prod_h_in [TRI];
   logic signed [PROD_W-1:0] prod_g_in [DIM];

   // The running sums and the sticky saturation flag.
   logic signed [SUM_W-1:0] h_sum_ff [TRI];
   logic signed [SUM_W-1:0] g_sum_ff [DIM];
   logic signed [SUM_W-1:0] h_sum_in [TRI];
   logic signed [SUM_W-1:0] g_sum_in [DIM];
   logic                    sat_ff, sat_in;

   // Readout row counter and the output register.
   logic [2:0]      row_ff, row_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;

   logic s2_is_read;
   logic out_free;
   logic s2_retire;
   logic s2_free;
   logic s1_move;
   logic accept;
   logic emit;

   // ---------------------------------------------------------------------
   // Flow control. The sum stage retires any item as soon as it holds it, except a
   // read, which stays there until its last row has entered the output
   // register. Everything upstream then waits behind it, so no later
   // accumulate can alter the sums halfway through a readout.
   // ---------------------------------------------------------------------
   assign s2_is_read = s2_valid_ff && (s2_cmd_ff == CMD_READ);
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign emit       = s2_is_read && out_free;
   assign s2_retire  = s2_valid_ff && ((s2_cmd_ff != CMD_READ) ||
                                       (out_free && (row_ff == LAST_ROW)));
   assign s2_free    = !s2_valid_ff || s2_retire;
   assign s1_move    = s1_valid_ff && s2_free;

   assign req_ch.ready = !s1_valid_ff || s2_free;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_free ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Input register. Jacobian elements go into an array so that the
   // product stage can walk them by index.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff    <= req_ch.payload.command;
         s1_jac_ff[0] <= req_ch.payload.jac_0;
         s1_jac_ff[1] <= req_ch.payload.jac_1;
         s1_jac_ff[2] <= req_ch.payload.jac_2;
         s1_jac_ff[3] <= req_ch.payload.jac_3;
         s1_jac_ff[4] <= req_ch.payload.jac_4;
         s1_jac_ff[5] <= req_ch.payload.jac_5;
         s1_res_ff    <= req_ch.payload.residual;
      end
   end

   // ---------------------------------------------------------------------
   // Product stage: 27 independent 24 by 24 signed multiplies, each exact
   // in 48 bits, written straight into upper-triangle order.
   // ---------------------------------------------------------------------
   always_comb begin
      prod_h_in = '{default: '0};
      for (int i = 0; i < DIM; i++) begin
         for (int k = 0; k < DIM; k++) begin
            if (k >= i) begin
               prod_h_in[TRI_INDEX[i][k]] = PROD_W'(s1_jac_ff[i]) * PROD_W'(s1_jac_ff[k]);
            end
         end
         prod_g_in[i] = PROD_W'(s1_jac_ff[i]) * PROD_W'(s1_res_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_cmd_ff <= s1_cmd_ff;
         prod_h_ff <= prod_h_in;
         prod_g_ff <= prod_g_in;
      end
   end

   // ---------------------------------------------------------------------
   // Sum stage. Each of the 27 sums has its own saturating adder; any one
   // of them clamping sets the sticky flag. A clear zeroes everything, and
   // the unused command code passes through without effect.
   // ---------------------------------------------------------------------
   always_comb begin
      sat_result_type res;
      h_sum_in = h_sum_ff;
      g_sum_in = g_sum_ff;
      sat_in   = sat_ff;
      res      = '0;
      if (s2_valid_ff && (s2_cmd_ff == CMD_ACCUM)) begin
         for (int t = 0; t < TRI; t++) begin
            res         = sat_accum(h_sum_ff[t], prod_h_ff[t]);
            h_sum_in[t] = res.value;
            sat_in      = sat_in | res.overflow;
         end
         for (int i = 0; i < DIM; i++) begin
            res         = sat_accum(g_sum_ff[i], prod_g_ff[i]);
            g_sum_in[i] = res.value;
            sat_in      = sat_in | res.overflow;
         end
      end else if (s2_valid_ff && (s2_cmd_ff == CMD_CLEAR)) begin
         for (int t = 0; t < TRI; t++) begin
            h_sum_in[t] = '0;
         end
         for (int i = 0; i < DIM; i++) begin
            g_sum_in[i] = '0;
         end
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < TRI; t++) begin
            h_sum_ff[t] <= '0;
         end
         for (int i = 0; i < DIM; i++) begin
            g_sum_ff[i] <= '0;
         end
         sat_ff <= 1'b0;
      end else begin
         h_sum_ff <= h_sum_in;
         g_sum_ff <= g_sum_in;
         sat_ff   <= sat_in;
      end
   end

   // ---------------------------------------------------------------------
   // Readout. The row counter steps each time a row enters the output
   // register and wraps after the last. Entries below the diagonal are
   // taken from their mirrored upper-triangle place.
   // ---------------------------------------------------------------------
   always_comb begin
      row_in = row_ff;
      if (emit) begin
         row_in = (row_ff == LAST_ROW) ? '0 : row_ff + 3'd1;
      end
   end

   always_comb begin
      logic signed [SUM_W-1:0] col [DIM];
      for (int k = 0; k < DIM; k++) begin
         col[k] = '0;
      end
      for (int r = 0; r < DIM; r++) begin
         if (row_ff == 3'(r)) begin
            for (int k = 0; k < DIM; k++) begin
               col[k] = h_sum_ff[TRI_INDEX[r][k]];
            end
         end
      end
      rsp_data_in.row       = row_ff;
      rsp_data_in.h_col0    = col[0];
      rsp_data_in.h_col1    = col[1];
      rsp_data_in.h_col2    = col[2];
      rsp_data_in.h_col3    = col[3];
      rsp_data_in.h_col4    = col[4];
      rsp_data_in.h_col5    = col[5];
      rsp_data_in.g_entry   = g_sum_ff[row_ff];
      rsp_data_in.saturated = sat_ff;
      rsp_data_in.last      = (row_ff == LAST_ROW);
      rsp_valid_in = out_free ? s2_is_read : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   `NEA_ASSERT_NOW(a_last_on_final_row, rsp_valid_ff && rsp_data_ff.last,
                   rsp_data_ff.row == LAST_ROW,
                   "last flag on a row other than the final one")
   `NEA_ASSERT_NOW(a_row_count_only_in_read, row_ff != '0, s2_is_read,
                   "readout row counter moved without a read in the sum stage")
   `NEA_ASSERT_NEXT(a_read_holds_sums, s2_is_read && !s2_retire,
                    s2_is_read && $stable(h_sum_ff[0]) && $stable(g_sum_ff[0]) && $stable(sat_ff),
                    "sums changed during a readout")
   `NEA_ASSERT_NEXT(a_clear_zeroes, s2_valid_ff && (s2_cmd_ff == CMD_CLEAR),
                    !sat_ff && (h_sum_ff[TRI-1] == '0) && (g_sum_ff[DIM-1] == '0),
                    "clear left a sum or the flag set")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the normal-equation accumulator: terms, clears and read-outs
// go in, and every returned row is checked against a model of the sums kept in the bench.
// Depends on nea_pkg, nea_req_if, nea_rsp_if and normal_equation_accumulator.
module tb;
   import nea_pkg::*;

   // The command code that the block must ignore.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Cycles without any handshake before the run is declared hung. A read-out stalled
   // by the response side is the slowest legal case, and it needs far fewer than this.
   localparam int unsigned QUIET_LIMIT = 4000;
   localparam int unsigned DRAIN_CYCLES = 16;

   // Length of the unbroken burst of full-scale terms.
   localparam int unsigned EXTREME_TERMS = 8;
   localparam int unsigned RANDOM_ITEMS = 120;

   localparam logic signed [JAC_W-1:0] JAC_MAX = {1'b0, {(JAC_W-1){1'b1}}};
   localparam logic signed [JAC_W-1:0] JAC_MIN = {1'b1, {(JAC_W-1){1'b0}}};

   // Keeps the full symmetric matrix and the gradient as the block should, and holds
   // the rows that read-outs have yet to deliver, oldest first.
   class nea_scoreboard;
      logic signed [SUM_W-1:0] h_full [DIM][DIM];
      logic signed [SUM_W-1:0] g_vec [DIM];
      bit                      sat_seen;
      rsp_payload_type         rows_due [$];
      int unsigned             failures;

      function new();
         zero_sums();
         failures = 0;
      endfunction

      function void zero_sums();
         foreach (h_full[i, k]) h_full[i][k] = '0;
         foreach (g_vec[i]) g_vec[i] = '0;
         sat_seen = 1'b0;
      endfunction

      // Exact 65-bit sum; the two top bits differ only when the 64-bit range is passed.
      function logic signed [SUM_W-1:0] clamp_add(logic signed [SUM_W-1:0] acc,
                                                  logic signed [SUM_W-1:0] term);
         logic [SUM_W:0] wide;
         wide = {acc[SUM_W-1], acc} + {term[SUM_W-1], term};
         if (wide[SUM_W] != wide[SUM_W-1]) begin
            sat_seen = 1'b1;
            return wide[SUM_W] ? SUM_MIN : SUM_MAX;
         end
         return wide[SUM_W-1:0];
      endfunction

      function void note_item(req_payload_type p);
         logic signed [SUM_W-1:0] j [DIM];
         logic signed [SUM_W-1:0] r;
         rsp_payload_type         row_out;
         j[0] = $signed(p.jac_0);
         j[1] = $signed(p.jac_1);
         j[2] = $signed(p.jac_2);
         j[3] = $signed(p.jac_3);
         j[4] = $signed(p.jac_4);
         j[5] = $signed(p.jac_5);
         r = $signed(p.residual);
         case (p.command)
            CMD_ACCUM: begin
               for (int i = 0; i < DIM; i++) begin
                  for (int k = i; k < DIM; k++) begin
                     h_full[i][k] = clamp_add(h_full[i][k], j[i] * j[k]);
                     h_full[k][i] = h_full[i][k];
                  end
                  g_vec[i] = clamp_add(g_vec[i], j[i] * r);
               end
            end
            CMD_CLEAR: begin
               zero_sums();
            end
            CMD_READ: begin
               for (int i = 0; i < DIM; i++) begin
                  row_out.row = 3'(i);
                  row_out.h_col0 = h_full[i][0];
                  row_out.h_col1 = h_full[i][1];
                  row_out.h_col2 = h_full[i][2];
                  row_out.h_col3 = h_full[i][3];
                  row_out.h_col4 = h_full[i][4];
                  row_out.h_col5 = h_full[i][5];
                  row_out.g_entry = g_vec[i];
                  row_out.saturated = sat_seen;
                  row_out.last = (3'(i) == LAST_ROW);
                  rows_due = {rows_due, row_out};
               end
            end
            default: begin
            end
         endcase
      endfunction

      function void compare_field(string fld_name, logic signed [SUM_W-1:0] want,
                                  logic signed [SUM_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", fld_name, want, got);
            failures++;
         end
      endfunction

      function void check_row(rsp_payload_type got);
         rsp_payload_type want;
         if (rows_due.size() == 0) begin
            $error("row %0d arrived with no row expected", got.row);
            failures++;
            return;
         end
         want = rows_due.pop_front();
         compare_field("row", want.row, got.row);
         compare_field("h_col0", want.h_col0, got.h_col0);
         compare_field("h_col1", want.h_col1, got.h_col1);
         compare_field("h_col2", want.h_col2, got.h_col2);
         compare_field("h_col3", want.h_col3, got.h_col3);
         compare_field("h_col4", want.h_col4, got.h_col4);
         compare_field("h_col5", want.h_col5, got.h_col5);
         compare_field("g_entry", want.g_entry, got.g_entry);
         compare_field("saturated", want.saturated, got.saturated);
         compare_field("last", want.last, got.last);
      endfunction

      function int unsigned pending();
         return rows_due.size();
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   int unsigned   req_idle_pct = 34;
   int unsigned   rsp_idle_pct = 34;
   int unsigned   quiet_cycles = 0;
   nea_scoreboard sums_model;

   nea_req_if req_link ();
   nea_rsp_if rsp_link ();

   normal_equation_accumulator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_link),
      .rsp_ch (rsp_link)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Mostly values from -1 to 1 in Q8.16, with a fair share of full-range values and
   // of the extremes, so that small sums and every bit pattern both turn up.
   function automatic logic signed [JAC_W-1:0] pick_value();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 30) begin
         return JAC_W'($urandom);
      end
      if (sel < 45) begin
         case ($urandom_range(4))
            0: return JAC_MAX;
            1: return JAC_MIN;
            2: return '0;
            3: return '1;
            default: return JAC_W'(1);
         endcase
      end
      return JAC_W'(int'($urandom_range(131071)) - 65536);
   endfunction

   function automatic req_payload_type make_term(logic [1:0] cmd,
                                                 logic signed [JAC_W-1:0] j0,
                                                 logic signed [JAC_W-1:0] j1,
                                                 logic signed [JAC_W-1:0] j2,
                                                 logic signed [JAC_W-1:0] j3,
                                                 logic signed [JAC_W-1:0] j4,
                                                 logic signed [JAC_W-1:0] j5,
                                                 logic signed [JAC_W-1:0] r);
      req_payload_type p;
      p.command = cmd;
      p.jac_0 = j0;
      p.jac_1 = j1;
      p.jac_2 = j2;
      p.jac_3 = j3;
      p.jac_4 = j4;
      p.jac_5 = j5;
      p.residual = r;
      return p;
   endfunction

   function automatic req_payload_type random_term(logic [1:0] cmd);
      return make_term(cmd, pick_value(), pick_value(), pick_value(), pick_value(),
                       pick_value(), pick_value(), pick_value());
   endfunction

   // Called at a rising edge; returns at the edge at which the item is taken. Valid is
   // left high so that a following item can go out in the next cycle unless idling is drawn.
   task automatic send_item(input req_payload_type p);
      while ($urandom_range(99) < req_idle_pct) begin
         req_link.valid <= 1'b0;
         @(posedge clock);
      end
      req_link.valid <= 1'b1;
      req_link.payload <= p;
      do begin
         @(posedge clock);
      end while (!req_link.ready);
      sums_model.note_item(p);
   endtask

   // Result side: check each row taken, then choose whether to stall the next cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_link.ready <= 1'b0;
      end else begin
         if (rsp_link.valid && rsp_link.ready) begin
            sums_model.check_row(rsp_link.payload);
         end
         rsp_link.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Watchdog: any handshake on either channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_link.valid && req_link.ready) || (rsp_link.valid && rsp_link.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned sel;
      sums_model = new();
      req_link.valid <= 1'b0;
      req_link.payload <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part: sums straight after reset, the field extremes, the ignored
      // command, clears and back-to-back read-outs.
      send_item(make_term(CMD_READ, '0, '0, '0, '0, '0, '0, '0));
      send_item(make_term(CMD_ACCUM, JAC_MAX, JAC_MAX, JAC_MAX, JAC_MAX, JAC_MAX, JAC_MAX,
                          JAC_MAX));
      send_item(make_term(CMD_ACCUM, JAC_MIN, JAC_MIN, JAC_MIN, JAC_MIN, JAC_MIN, JAC_MIN,
                          JAC_MIN));
      send_item(make_term(CMD_ACCUM, JAC_MIN, JAC_MAX, JAC_MIN, JAC_MAX, JAC_MIN, JAC_MAX,
                          JAC_MAX));
      send_item(make_term(CMD_ACCUM, '0, '0, '0, '0, '0, '0, JAC_MIN));
      send_item(make_term(CMD_ACCUM, JAC_W'(1), '1, JAC_W'(65536), JAC_W'(-65536), '0,
                          JAC_W'(3), '1));
      send_item(random_term(CMD_UNUSED));
      send_item(make_term(CMD_READ, '1, '1, '1, '1, '1, '1, '1));
      send_item(make_term(CMD_CLEAR, JAC_MAX, JAC_MIN, JAC_MAX, JAC_MIN, JAC_MAX, JAC_MIN,
                          JAC_MAX));
      send_item(random_term(CMD_READ));
      send_item(random_term(CMD_ACCUM));
      send_item(make_term(CMD_UNUSED, JAC_MAX, JAC_MAX, JAC_MAX, JAC_MAX, JAC_MAX, JAC_MAX,
                          JAC_MAX));
      send_item(random_term(CMD_ACCUM));
      send_item(random_term(CMD_READ));
      send_item(random_term(CMD_READ));
      send_item(random_term(CMD_CLEAR));
      send_item(random_term(CMD_UNUSED));
      send_item(random_term(CMD_READ));

      // Extremes: an unbroken burst of full-scale terms drives every H and g entry far
      // from zero. Mixed signs between the two halves of the row send the cross terms
      // and half of g negative. The 64-bit range is out of reach in a run this short.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_item(random_term(CMD_CLEAR));
      repeat (EXTREME_TERMS) begin
         send_item(make_term(CMD_ACCUM, JAC_MIN, JAC_MIN, JAC_MIN, JAC_MAX, JAC_MAX, JAC_MAX,
                             JAC_MIN));
      end
      send_item(random_term(CMD_READ));
      req_idle_pct = 34;
      rsp_idle_pct = 34;
      // Further terms move the sums on again, and the clear must zero all of them.
      repeat (4) send_item(random_term(CMD_ACCUM));
      send_item(random_term(CMD_READ));
      send_item(random_term(CMD_CLEAR));
      send_item(random_term(CMD_READ));

      // Random part: mostly accumulations with random content, with read-outs, clears
      // and the ignored command mixed in. A stretch in the middle runs without idling.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 50) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else if (n == 90) begin
            req_idle_pct = 34;
            rsp_idle_pct = 34;
         end
         sel = $urandom_range(99);
         if (sel < 9) begin
            send_item(random_term(CMD_READ));
         end else if (sel < 13) begin
            send_item(random_term(CMD_CLEAR));
         end else if (sel < 16) begin
            send_item(random_term(CMD_UNUSED));
         end else begin
            send_item(random_term(CMD_ACCUM));
         end
      end
      send_item(random_term(CMD_READ));
      req_link.valid <= 1'b0;

      // The watchdog ends the run if expected rows never come.
      while (sums_model.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sums_model.failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
